// File: rtl/multi_channel_timer_top_defines.svh
// assertion macros for the multi-channel timer
`ifndef MULTI_CHANNEL_TIMER_TOP_DEFINES_SVH
`define MULTI_CHANNEL_TIMER_TOP_DEFINES_SVH

// same-cycle implication
`define MCT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mct assertion failed");

// next-cycle implication
`define MCT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mct assertion failed");

`endif

// File: rtl/mct_pkg.sv
// shared constants and types for the multi-channel timer
package mct_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int CPU_COUNT   = 4;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_ARM    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  typedef struct packed {
    logic arm;
    logic remove;
    logic scan_start;
    logic scan_step;
    logic drain;
  } mct_cmd_t;

  typedef struct packed {
    logic scan_end;
  } mct_stat_t;

endpackage

// File: rtl/mct_ctrl.sv
// controller state machine for the multi-channel timer
module mct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [2:0]        timer_id,
  input  mct_pkg::mct_stat_t stat,
  output mct_pkg::mct_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   id_ok;

  always_comb begin
    accept         = start && (state == ST_IDLE);
    id_ok          = int'(timer_id) < mct_pkg::TIMER_COUNT;
    cmd.arm        = accept && (func == mct_pkg::FUNC_ARM) && id_ok;
    cmd.remove     = accept && (func == mct_pkg::FUNC_REMOVE) && id_ok;
    cmd.scan_start = accept && (func == mct_pkg::FUNC_TICK);
    cmd.scan_step  = (state == ST_SCAN);
    cmd.drain      = (state == ST_DRAIN);
    busy           = (state != ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.scan_start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/mct_datapath.sv
// timer state, scan pointer and result registers for the multi-channel timer
`include "multi_channel_timer_top_defines.svh"

module mct_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mct_pkg::mct_cmd_t  cmd,
  output mct_pkg::mct_stat_t stat,
  input  logic [2:0]         timer_id,
  input  logic [31:0]        timeout,
  input  logic               repeat_req,
  input  logic [1:0]         cpu_id,
  output logic               result_valid,
  output logic [2:0]         fired_timer,
  output logic [1:0]         wake_cpu,
  output logic               last
);

  logic [31:0] remaining [mct_pkg::TIMER_COUNT];
  logic [31:0] period    [mct_pkg::TIMER_COUNT];
  logic        periodic  [mct_pkg::TIMER_COUNT];
  logic        armed     [mct_pkg::TIMER_COUNT];
  logic [1:0]  owner_cpu [mct_pkg::TIMER_COUNT];

  logic [mct_pkg::IDX_W-1:0] scan_idx;
  logic [mct_pkg::CNT_W-1:0] fire_cnt;
  logic                      pend_valid;
  logic [2:0]                pend_timer;
  logic [1:0]                pend_cpu;

  logic [mct_pkg::IDX_W+2:0] id_pad;
  logic [mct_pkg::IDX_W+2:0] scan_pad;
  logic [mct_pkg::IDX_W-1:0] cmd_idx;
  logic [1:0]                cpu_clamped;
  logic                      cur_armed;
  logic                      rem_gt1;
  logic                      fire;
  logic                      count_down;

  always_comb begin
    id_pad      = (mct_pkg::IDX_W + 3)'(timer_id);
    cmd_idx     = id_pad[mct_pkg::IDX_W-1:0];
    scan_pad    = (mct_pkg::IDX_W + 3)'(scan_idx);
    cpu_clamped = (int'(cpu_id) >= mct_pkg::CPU_COUNT) ? 2'(mct_pkg::CPU_COUNT - 1) : cpu_id;
    cur_armed   = armed[scan_idx];
    rem_gt1     = remaining[scan_idx] > 32'd1;
    count_down  = cmd.scan_step && cur_armed && rem_gt1;
    fire        = cmd.scan_step && cur_armed && !rem_gt1 &&
                  (fire_cnt < mct_pkg::CNT_W'(mct_pkg::MAX_RESULTS));
    stat.scan_end = (scan_idx == mct_pkg::IDX_W'(mct_pkg::TIMER_COUNT - 1));
  end

  // armed flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mct_pkg::TIMER_COUNT; i++) armed[i] <= 1'b0;
    end else if (cmd.arm) begin
      armed[cmd_idx] <= 1'b1;
    end else if (cmd.remove) begin
      armed[cmd_idx] <= 1'b0;
    end else if (fire && !periodic[scan_idx]) begin
      armed[scan_idx] <= 1'b0;
    end
  end

  // per-timer payload
  always_ff @(posedge clk) begin
    if (cmd.arm) begin
      remaining[cmd_idx] <= timeout;
      period[cmd_idx]    <= timeout;
      periodic[cmd_idx]  <= repeat_req;
      owner_cpu[cmd_idx] <= cpu_clamped;
    end else if (cmd.remove) begin
      remaining[cmd_idx] <= '0;
      period[cmd_idx]    <= '0;
      periodic[cmd_idx]  <= 1'b0;
      owner_cpu[cmd_idx] <= '0;
    end else if (count_down) begin
      remaining[scan_idx] <= remaining[scan_idx] - 32'd1;
    end else if (fire) begin
      if (periodic[scan_idx]) begin
        remaining[scan_idx] <= period[scan_idx];
      end else begin
        remaining[scan_idx] <= '0;
        period[scan_idx]    <= '0;
      end
    end
  end

  // scan control and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx     <= '0;
      fire_cnt     <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (fire || cmd.drain) && pend_valid;
      if (cmd.scan_start) begin
        scan_idx   <= '0;
        fire_cnt   <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
        if (fire) begin
          fire_cnt   <= fire_cnt + 1'b1;
          pend_valid <= 1'b1;
        end else if (cmd.drain) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  // held expiry and result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      fired_timer <= pend_timer;
      wake_cpu    <= pend_cpu;
      last        <= 1'b0;
      pend_timer  <= scan_pad[2:0];
      pend_cpu    <= owner_cpu[scan_idx];
    end else if (cmd.drain) begin
      fired_timer <= pend_timer;
      wake_cpu    <= pend_cpu;
      last        <= 1'b1;
    end
  end

  `MCT_ASSERT_IMP(a_last_clears_pend, clk, rst, result_valid && last, !pend_valid)
  `MCT_ASSERT_NXT(a_drain_empties, clk, rst, cmd.drain, !pend_valid)
  `MCT_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1,
                  fire_cnt <= mct_pkg::CNT_W'(mct_pkg::MAX_RESULTS))
  `MCT_ASSERT_IMP(a_no_fire_idle, clk, rst, !cmd.scan_step, !fire)

endmodule

// File: rtl/multi_channel_timer_top.sv
// top level of the multi-channel countdown timer bank
//
// channel   direction  handshake                fields
// request   in         start high, busy low     func timer_id timeout repeat_req cpu_id
// result    out        result_valid, 1 cycle    fired_timer wake_cpu last
//
// arm and remove requests complete in the accept cycle; busy stays low
// a tick request scans one timer per cycle, then drains; busy is high through the scan and the drain
// expiries leave in ascending timer order, last on the final one
// the final result of a tick appears in the first cycle after busy falls
// rst is synchronous and disarms every timer; results cannot be stalled
module multi_channel_timer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [2:0]  timer_id,
  input  logic [31:0] timeout,
  input  logic        repeat_req,
  input  logic [1:0]  cpu_id,
  output logic        result_valid,
  output logic [2:0]  fired_timer,
  output logic [1:0]  wake_cpu,
  output logic        last
);

  mct_pkg::mct_cmd_t  cmd;
  mct_pkg::mct_stat_t stat;

  mct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (func),
    .timer_id (timer_id),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  mct_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .timer_id     (timer_id),
    .timeout      (timeout),
    .repeat_req   (repeat_req),
    .cpu_id       (cpu_id),
    .result_valid (result_valid),
    .fired_timer  (fired_timer),
    .wake_cpu     (wake_cpu),
    .last         (last)
  );

endmodule
